FILE: hw/rtl/sfdn_pkg.sv
package sfdn_pkg;

	// Line depth is a power of two; pointer arithmetic wraps in ADDR_BITS.
	localparam int LINE_DEPTH  = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_BITS   = $clog2(LINE_DEPTH);

	localparam int NUM_LINES  = 4;
	localparam int LINE_BITS  = 2;
	localparam int IO_BITS    = 16;
	localparam int GAIN_BITS  = 16;
	localparam int DELAY_BITS = 12;
	localparam int WORK_BITS  = ((SAMPLE_BITS > IO_BITS) ? SAMPLE_BITS : IO_BITS) + 2;
	localparam int MIX_BITS   = WORK_BITS + 2;
	localparam int PROD_BITS  = GAIN_BITS + 1 + WORK_BITS;

	localparam int MUL_STEPS = 14;
	localparam int STEP_BITS = 4;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(32768);

	localparam logic [CFG_INDEX_BITS-1:0] REG_LIVENESS_GAIN  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SMOOTHING_COEF = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DAMPING_MIX    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WET_LEVEL      = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_DELAY_A    = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_DELAY_B    = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_DELAY_C    = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_DELAY_D    = 3'd7;

	typedef struct packed {
		logic signed [IO_BITS-1:0] right_in;
		logic signed [IO_BITS-1:0] left_in;
	} in_item_t;

	typedef struct packed {
		logic signed [IO_BITS-1:0] right_out;
		logic signed [IO_BITS-1:0] left_out;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_SMOOTH,
		OP_DAMP,
		OP_LIVE,
		OP_WET
	} mul_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_MIX,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic                 rd_en;
		logic                 load_tap;
		logic                 mul_en;
		mul_op_t              mul_op;
		logic [LINE_BITS-1:0] mul_line;
		logic                 wr_en;
		logic                 out_load;
	} dp_cmd_t;

	function automatic logic [GAIN_BITS-1:0] clamp_gain(input logic [GAIN_BITS-1:0] g);
		return (g > GAIN_UNITY) ? GAIN_UNITY : g;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [MIX_BITS-1:0] x);
		logic signed [MIX_BITS-1:0] hi;
		logic signed [MIX_BITS-1:0] lo;
		hi = MIX_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
		lo = -hi - MIX_BITS'(1);
		if (x > hi) begin
			return hi[SAMPLE_BITS-1:0];
		end else if (x < lo) begin
			return lo[SAMPLE_BITS-1:0];
		end
		return x[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic signed [IO_BITS-1:0] sat_io(input logic signed [MIX_BITS-1:0] x);
		logic signed [MIX_BITS-1:0] hi;
		logic signed [MIX_BITS-1:0] lo;
		hi = MIX_BITS'((1 << (IO_BITS - 1)) - 1);
		lo = -hi - MIX_BITS'(1);
		if (x > hi) begin
			return hi[IO_BITS-1:0];
		end else if (x < lo) begin
			return lo[IO_BITS-1:0];
		end
		return x[IO_BITS-1:0];
	endfunction

endpackage

FILE: hw/rtl/sfdn_ram.sv
module sfdn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/sfdn_ctrl.sv
module sfdn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output sfdn_pkg::dp_cmd_t cmd
);

	sfdn_pkg::ctrl_state_t state_q;
	sfdn_pkg::ctrl_state_t state_d;
	logic [sfdn_pkg::STEP_BITS-1:0] step_q;
	logic out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sfdn_pkg::ST_IDLE;
			step_q     <= '0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sfdn_pkg::ST_MUL) begin
				step_q <= step_q + sfdn_pkg::STEP_BITS'(1);
			end else begin
				step_q <= '0;
			end
			if (cmd.out_load) begin
				out_full_q <= 1'b1;
			end else if (out_ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sfdn_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.rd_en = 1'b1;
					state_d   = sfdn_pkg::ST_LOAD;
				end
			end
			sfdn_pkg::ST_LOAD: begin
				cmd.load_tap = 1'b1;
				state_d      = sfdn_pkg::ST_MUL;
			end
			sfdn_pkg::ST_MUL: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_op   = sfdn_pkg::mul_op_t'(step_q[3:2]);
				cmd.mul_line = step_q[1:0];
				if (step_q == sfdn_pkg::STEP_BITS'(sfdn_pkg::MUL_STEPS - 1)) begin
					state_d = sfdn_pkg::ST_MIX;
				end
			end
			sfdn_pkg::ST_MIX: begin
				cmd.wr_en = 1'b1;
				state_d   = sfdn_pkg::ST_DONE;
			end
			sfdn_pkg::ST_DONE: begin
				if (!out_full_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = sfdn_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sfdn_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_full_q;

endmodule

FILE: hw/rtl/sfdn_dp.sv
module sfdn_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sfdn_pkg::dp_cmd_t                       cmd,
	input  sfdn_pkg::in_item_t                      in_data,
	output sfdn_pkg::out_item_t                     out_data,
	input  logic                                    cfg_we,
	input  logic [sfdn_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [sfdn_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

	localparam int AW = sfdn_pkg::ADDR_BITS;
	localparam int SB = sfdn_pkg::SAMPLE_BITS;
	localparam int WB = sfdn_pkg::WORK_BITS;
	localparam int MB = sfdn_pkg::MIX_BITS;
	localparam int PB = sfdn_pkg::PROD_BITS;
	localparam int GB = sfdn_pkg::GAIN_BITS;
	localparam int DB = sfdn_pkg::DELAY_BITS;
	localparam int NL = sfdn_pkg::NUM_LINES;

	// configuration
	logic [GB-1:0] live_q;
	logic [GB-1:0] coef_q;
	logic [GB-1:0] damp_q;
	logic [GB-1:0] wet_q;
	logic [DB-1:0] delay_q [NL];

	// line bookkeeping; wrapped_q marks every slot as written at least once
	logic [AW-1:0] wp_q;
	logic          wrapped_q;

	sfdn_pkg::in_item_t  in_q;
	sfdn_pkg::out_item_t out_q;
	logic signed [sfdn_pkg::IO_BITS-1:0] rout_q;
	logic signed [sfdn_pkg::IO_BITS-1:0] lout_q;

	logic                 tap_ok_q [NL];
	logic signed [SB-1:0] t_q      [NL];
	logic signed [SB-1:0] s_q      [NL];
	logic signed [WB-1:0] y_q      [NL];
	logic signed [WB-1:0] v_q      [NL];

	logic [AW-1:0]        raddr   [NL];
	logic                 raddr_ok[NL];
	logic [SB-1:0]        rdata   [NL];
	logic [SB-1:0]        wdata   [NL];

	logic signed [GB:0]   mul_a;
	logic signed [WB-1:0] mul_b;
	logic signed [PB-1:0] prod_s1;
	sfdn_pkg::mul_op_t    op_s1;
	logic [sfdn_pkg::LINE_BITS-1:0] line_s1;
	logic                 post_s1;

	logic signed [PB-1:0] prod_h15;
	logic signed [PB-1:0] prod_h16;
	logic signed [MB-1:0] r15;
	logic signed [MB-1:0] r16;
	logic signed [MB-1:0] in_term;
	logic signed [MB-1:0] va, vb, vc, vd;

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			logic [AW+DB-1:0] d;
			d = (AW+DB)'(wp_q) - (AW+DB)'(delay_q[k]);
			raddr[k]    = d[AW-1:0];
			raddr_ok[k] = wrapped_q || (raddr[k] < wp_q);
		end
	end

	always_comb begin
		va = MB'(v_q[0]);
		vb = MB'(v_q[1]);
		vc = MB'(v_q[2]);
		vd = MB'(v_q[3]);
		wdata[0] = sfdn_pkg::sat_sample(va + vb + vc + vd);
		wdata[1] = sfdn_pkg::sat_sample(va - vb + vc - vd);
		wdata[2] = sfdn_pkg::sat_sample(va + vb - vc - vd);
		wdata[3] = sfdn_pkg::sat_sample(va - vb - vc + vd);
	end

	for (genvar k = 0; k < NL; k++) begin : g_line
		sfdn_ram #(
			.WIDTH(SB),
			.DEPTH(sfdn_pkg::LINE_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (cmd.wr_en),
			.waddr(wp_q),
			.wdata(wdata[k]),
			.re   (cmd.rd_en),
			.raddr(raddr[k]),
			.rdata(rdata[k])
		);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_op)
			sfdn_pkg::OP_SMOOTH: begin
				mul_a = {1'b0, coef_q};
				mul_b = WB'(t_q[cmd.mul_line]) - WB'(s_q[cmd.mul_line]);
			end
			sfdn_pkg::OP_DAMP: begin
				mul_a = {1'b0, damp_q};
				mul_b = WB'(t_q[cmd.mul_line]) - WB'(s_q[cmd.mul_line]);
			end
			sfdn_pkg::OP_LIVE: begin
				mul_a = {1'b0, live_q};
				mul_b = y_q[cmd.mul_line];
			end
			sfdn_pkg::OP_WET: begin
				mul_a = {1'b0, wet_q};
				mul_b = v_q[cmd.mul_line];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// round half up after the product register
	assign prod_h15 = prod_s1 + PB'(1 << 14);
	assign prod_h16 = prod_s1 + PB'(1 << 15);
	assign r15      = MB'(prod_h15 >>> 15);
	assign r16      = MB'(prod_h16 >>> 16);

	always_comb begin
		case (line_s1)
			2'd0:    in_term = MB'(in_q.right_in);
			2'd1:    in_term = MB'(in_q.left_in);
			default: in_term = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q    <= GB'(27853);
			coef_q    <= GB'(14005);
			damp_q    <= GB'(16384);
			wet_q     <= '0;
			delay_q[0] <= DB'(2586);
			delay_q[1] <= DB'(3062);
			delay_q[2] <= DB'(3286);
			delay_q[3] <= DB'(3798);
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			post_s1   <= 1'b0;
			for (int k = 0; k < NL; k++) begin
				s_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sfdn_pkg::REG_LIVENESS_GAIN:  live_q <= sfdn_pkg::clamp_gain(cfg_data);
					sfdn_pkg::REG_SMOOTHING_COEF: coef_q <= sfdn_pkg::clamp_gain(cfg_data);
					sfdn_pkg::REG_DAMPING_MIX:    damp_q <= sfdn_pkg::clamp_gain(cfg_data);
					sfdn_pkg::REG_WET_LEVEL:      wet_q  <= sfdn_pkg::clamp_gain(cfg_data);
					sfdn_pkg::REG_TAP_DELAY_A:    delay_q[0] <= cfg_data[DB-1:0];
					sfdn_pkg::REG_TAP_DELAY_B:    delay_q[1] <= cfg_data[DB-1:0];
					sfdn_pkg::REG_TAP_DELAY_C:    delay_q[2] <= cfg_data[DB-1:0];
					sfdn_pkg::REG_TAP_DELAY_D:    delay_q[3] <= cfg_data[DB-1:0];
					default: ;
				endcase
			end
			if (cmd.wr_en) begin
				wp_q <= wp_q + AW'(1);
				if (wp_q == AW'(sfdn_pkg::LINE_DEPTH - 1)) begin
					wrapped_q <= 1'b1;
				end
			end
			post_s1 <= cmd.mul_en;
			if (post_s1 && (op_s1 == sfdn_pkg::OP_SMOOTH)) begin
				s_q[line_s1] <= sfdn_pkg::sat_sample(MB'(s_q[line_s1]) + r15);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			in_q <= in_data;
			for (int k = 0; k < NL; k++) begin
				tap_ok_q[k] <= raddr_ok[k];
			end
		end
		if (cmd.load_tap) begin
			for (int k = 0; k < NL; k++) begin
				t_q[k] <= tap_ok_q[k] ? rdata[k] : '0;
			end
		end
		if (cmd.mul_en) begin
			prod_s1 <= mul_a * mul_b;
			op_s1   <= cmd.mul_op;
			line_s1 <= cmd.mul_line;
		end
		if (post_s1) begin
			case (op_s1)
				sfdn_pkg::OP_DAMP: y_q[line_s1] <= WB'(MB'(s_q[line_s1]) + r15);
				sfdn_pkg::OP_LIVE: v_q[line_s1] <= WB'(r16 + in_term);
				sfdn_pkg::OP_WET: begin
					if (line_s1 == 2'd0) begin
						rout_q <= sfdn_pkg::sat_io(in_term + r15);
					end else begin
						lout_q <= sfdn_pkg::sat_io(in_term + r15);
					end
				end
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			out_q.right_out <= rout_q;
			out_q.left_out  <= lout_q;
		end
	end

	assign out_data = out_q;

endmodule

FILE: hw/rtl/stereo_fdn_reverb.sv
// Flow: an accepted item passes LOAD, MUL, MIX and DONE; DONE waits for a free output.
// One item in flight: the single shared multiplier does fourteen products per item
//   besides tap read and line write; no new input is taken until DONE is left.
// Reset: arst_n clears control, config (to defaults), write pointer and smoothers.
//   Line memories are not cleared; a fill mark makes unwritten slots read as zero.
module stereo_fdn_reverb (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  sfdn_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output sfdn_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [sfdn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [sfdn_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	sfdn_pkg::dp_cmd_t cmd;

	sfdn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	sfdn_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

`ifndef SYNTHESIS
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("result register overwritten before transfer");

	a_work_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_en || cmd.wr_en || cmd.load_tap) |-> !in_ready)
		else $error("datapath command issued while idle");
`endif

endmodule

FILE: dv/sfdn_reverb_checker.sv
module sfdn_reverb_checker
	import sfdn_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  in_item_t                  in_data,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  out_item_t                 out_data,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int                        errors,
	output int                        pending
);

	logic signed [SAMPLE_BITS-1:0] echo_line [NUM_LINES][LINE_DEPTH];
	logic signed [SAMPLE_BITS-1:0] lp_state [NUM_LINES];
	logic [ADDR_BITS-1:0]          wr_ptr;
	logic [GAIN_BITS-1:0]          live_g;
	logic [GAIN_BITS-1:0]          smooth_g;
	logic [GAIN_BITS-1:0]          damp_g;
	logic [GAIN_BITS-1:0]          wet_g;
	logic [DELAY_BITS-1:0]         tap_dly [NUM_LINES];
	out_item_t                     reverb_due [$];
	int                            err_count = 0;

	// floor(v / 2^sh + 1/2)
	function automatic longint round_shift(longint v, int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic longint clip(longint v, int bits);
		longint hi;
		hi = (longint'(1) << (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic logic [GAIN_BITS-1:0] cap_unity(logic [CFG_DATA_BITS-1:0] g);
		return (g > GAIN_UNITY) ? GAIN_UNITY : GAIN_BITS'(g);
	endfunction

	function automatic out_item_t reverb_step(in_item_t x);
		longint               v [NUM_LINES];
		longint               t;
		longint               s;
		longint               y;
		logic [ADDR_BITS-1:0] rd;
		out_item_t            res;
		for (int k = 0; k < NUM_LINES; k++) begin
			rd = wr_ptr - ADDR_BITS'(tap_dly[k]);
			t = echo_line[k][rd];
			s = lp_state[k];
			s = clip(s + round_shift(longint'(smooth_g) * (t - s), 15), SAMPLE_BITS);
			lp_state[k] = SAMPLE_BITS'(s);
			y = s + round_shift(longint'(damp_g) * (t - s), 15);
			v[k] = round_shift(longint'(live_g) * y, 16);
		end
		v[0] += longint'(x.right_in);
		v[1] += longint'(x.left_in);
		res.right_out = IO_BITS'(clip(longint'(x.right_in)
			+ round_shift(longint'(wet_g) * v[0], 15), IO_BITS));
		res.left_out = IO_BITS'(clip(longint'(x.left_in)
			+ round_shift(longint'(wet_g) * v[1], 15), IO_BITS));
		echo_line[0][wr_ptr] = SAMPLE_BITS'(clip(v[0] + v[1] + v[2] + v[3], SAMPLE_BITS));
		echo_line[1][wr_ptr] = SAMPLE_BITS'(clip(v[0] - v[1] + v[2] - v[3], SAMPLE_BITS));
		echo_line[2][wr_ptr] = SAMPLE_BITS'(clip(v[0] + v[1] - v[2] - v[3], SAMPLE_BITS));
		echo_line[3][wr_ptr] = SAMPLE_BITS'(clip(v[0] - v[1] - v[2] + v[3], SAMPLE_BITS));
		wr_ptr = wr_ptr + 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t due;
		if (!arst_n) begin
			for (int k = 0; k < NUM_LINES; k++) begin
				for (int i = 0; i < LINE_DEPTH; i++) begin
					echo_line[k][i] = '0;
				end
				lp_state[k] = '0;
			end
			wr_ptr = '0;
			live_g = 16'd27853;
			smooth_g = 16'd14005;
			damp_g = 16'd16384;
			wet_g = 16'd0;
			tap_dly[0] = 12'd2586;
			tap_dly[1] = 12'd3062;
			tap_dly[2] = 12'd3286;
			tap_dly[3] = 12'd3798;
			reverb_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LIVENESS_GAIN:  live_g = cap_unity(cfg_data);
					REG_SMOOTHING_COEF: smooth_g = cap_unity(cfg_data);
					REG_DAMPING_MIX:    damp_g = cap_unity(cfg_data);
					REG_WET_LEVEL:      wet_g = cap_unity(cfg_data);
					REG_TAP_DELAY_A:    tap_dly[0] = cfg_data[DELAY_BITS-1:0];
					REG_TAP_DELAY_B:    tap_dly[1] = cfg_data[DELAY_BITS-1:0];
					REG_TAP_DELAY_C:    tap_dly[2] = cfg_data[DELAY_BITS-1:0];
					REG_TAP_DELAY_D:    tap_dly[3] = cfg_data[DELAY_BITS-1:0];
				endcase
			end
			if (in_valid && in_ready) begin
				reverb_due.push_back(reverb_step(in_data));
			end
			if (out_valid && out_ready) begin
				if (reverb_due.size() == 0) begin
					$error("unexpected output transfer: right_out=%0d left_out=%0d",
						out_data.right_out, out_data.left_out);
					err_count++;
				end else begin
					due = reverb_due.pop_front();
					if (out_data.right_out !== due.right_out) begin
						$error("right_out: expected %0d, actual %0d",
							due.right_out, out_data.right_out);
						err_count++;
					end
					if (out_data.left_out !== due.left_out) begin
						$error("left_out: expected %0d, actual %0d",
							due.left_out, out_data.left_out);
						err_count++;
					end
				end
			end
		end
		errors <= err_count;
		pending <= reverb_due.size();
	end

endmodule

FILE: dv/tb_stereo_fdn_reverb.sv
module tb_stereo_fdn_reverb;
	import sfdn_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int RAND_PHASES   = 8;
	localparam int PHASE_ITEMS   = 54;
	localparam int DIRECTED      = 18;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	in_item_t                  in_data = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	out_item_t                 out_data;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_LIVENESS_GAIN;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	int                        errors;
	int                        pending;
	int                        sent = 0;
	int                        idle_run = 0;
	bit                        steady = 1'b0;
	bit                        stall_req = 1'b0;

	logic [IO_BITS-1:0] dir_r [DIRECTED] = '{
		16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
		16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555,
		16'hAAAA, 16'h0000};
	logic [IO_BITS-1:0] dir_l [DIRECTED] = '{
		16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
		16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 16'hAAAA,
		16'h5555, 16'h8000};
	logic [IO_BITS-1:0] corner_vals [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};

	always #1 clk = ~clk;

	stereo_fdn_reverb dut (.*);

	sfdn_reverb_checker chk (.*);

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_DATA_BITS-1:0] live, smooth, damp, wet,
		input logic [CFG_DATA_BITS-1:0] da, db, dc, dd);
		write_reg(REG_LIVENESS_GAIN, live);
		write_reg(REG_SMOOTHING_COEF, smooth);
		write_reg(REG_DAMPING_MIX, damp);
		write_reg(REG_WET_LEVEL, wet);
		write_reg(REG_TAP_DELAY_A, da);
		write_reg(REG_TAP_DELAY_B, db);
		write_reg(REG_TAP_DELAY_C, dc);
		write_reg(REG_TAP_DELAY_D, dd);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pair(input logic [IO_BITS-1:0] r, l);
		in_valid <= 1'b1;
		in_data <= {r, l};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	// wait for every expected result, then let the datapath go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic maybe_gap();
		if (!steady && $urandom_range(0, 99) < 26) begin
			in_valid <= 1'b0;
			in_data <= $urandom;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic in_item_t pick_pair();
		in_item_t x;
		x = $urandom;
		case ($urandom_range(0, 9))
			6, 7: begin
				x.right_in = IO_BITS'(int'($urandom_range(0, 1000)) - 500);
				x.left_in = IO_BITS'(int'($urandom_range(0, 1000)) - 500);
			end
			8: begin
				x.right_in = corner_vals[$urandom_range(0, 3)];
				x.left_in = corner_vals[$urandom_range(0, 3)];
			end
			9: x.left_in = '0;
			default: ;
		endcase
		return x;
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] pick_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return GAIN_UNITY;
			2: return CFG_DATA_BITS'($urandom_range(32769, 65535));
			default: return CFG_DATA_BITS'($urandom_range(0, 32768));
		endcase
	endfunction

	// upper bits are junk and must be dropped by the block
	function automatic logic [CFG_DATA_BITS-1:0] pick_delay();
		logic [DELAY_BITS-1:0] d;
		case ($urandom_range(0, 7))
			0: d = '0;
			1: d = '1;
			2: d = DELAY_BITS'($urandom);
			default: d = DELAY_BITS'($urandom_range(1, 300));
		endcase
		return {4'($urandom), d};
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_run <= 0;
			end else begin
				idle_run <= idle_run + 1;
			end
			if (idle_run >= STALL_LIMIT) begin
				$error("no transfer for %0d cycles, %0d results outstanding", idle_run, pending);
				$display("tb_stereo_fdn_reverb NOT OK");
				$finish;
			end
		end
	end

	initial begin : sink
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= steady || ($urandom_range(0, 99) >= 26);
			end
		end
	end

	initial begin : stimulus
		in_item_t x;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: wet level zero passes the dry input straight through
		send_pair(16'h7FFF, 16'h8000);
		send_pair(16'h8000, 16'h7FFF);
		send_pair(16'h1234, 16'h0000);
		settle();

		program_regs(16'd32768, 16'd32768, 16'd0, 16'd32768, 16'd1, 16'd2, 16'd3, 16'd4);
		for (int i = 0; i < DIRECTED; i++) begin
			send_pair(dir_r[i], dir_l[i]);
		end
		settle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: program_regs(16'hFFFF, 16'd40000, 16'd32769, 16'hFFFF,
					16'hF005, 16'hA011, 16'h5003, 16'hF017);
				1: program_regs(16'd0, 16'd0, 16'd0, 16'd0,
					16'd0, 16'd4095, 16'd0, 16'hFFFF);
				2: program_regs(16'd32768, 16'd0, 16'd32768, 16'd16384,
					16'd7, 16'd13, 16'd29, 16'd41);
				default: program_regs(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
					pick_delay(), pick_delay(), pick_delay(), pick_delay());
			endcase
			steady = (p == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 4 && i == 5) begin
					stall_req = 1'b1;
				end
				maybe_gap();
				x = pick_pair();
				send_pair(x.right_in, x.left_in);
			end
			settle();
		end
		steady = 1'b0;

		$display("Covered %0d sample pairs: reset defaults, unity, above-unity and zero gains,",
			sent);
		$display("zero and maximal tap delays, saturation, a long output hold, %0d random setups.",
			RAND_PHASES - 3);
		if (errors == 0 && pending == 0) begin
			$display("tb_stereo_fdn_reverb OK");
		end else begin
			$display("tb_stereo_fdn_reverb NOT OK");
		end
		$finish;
	end

endmodule
